[hdl/iir_half_band_oversampler_top_macros.svh]
// Assertion helpers for the oversampler top module
`ifndef IIR_HALF_BAND_OVERSAMPLER_TOP_MACROS_SVH
`define IIR_HALF_BAND_OVERSAMPLER_TOP_MACROS_SVH

// implication checked every cycle outside reset
`define IHB_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);

// next-cycle implication checked outside reset
`define IHB_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);

`endif

[hdl/ihb_pkg.sv]
package ihb_pkg;

  localparam int CHANNELS = 2;
  localparam int MAX_TAPS = 16;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TAP_W    = $clog2(MAX_TAPS);
  localparam int CNT_W    = TAP_W + 1;
  localparam int HIST_W   = CH_W + 1 + TAP_W;   // {channel, down, ring address}
  localparam int ACC_W    = 64;

  typedef enum logic [1:0] {
    CMD_LOAD_B = 2'd0,
    CMD_LOAD_A = 2'd1,
    CMD_UP     = 2'd2,
    CMD_DOWN   = 2'd3
  } cmd_t;

  localparam logic CFG_FF = 1'b0;
  localparam logic CFG_FB = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FF,
    ST_FB,
    ST_DRAIN,
    ST_ROUND,
    ST_OUT
  } state_t;

  // clamp a tap count to 1..MAX_TAPS
  function automatic logic [CNT_W-1:0] clamp_taps(input logic [4:0] t);
    logic [CNT_W-1:0] r;
    begin
      if (t == 5'd0) r = CNT_W'(1);
      else if (32'(t) > MAX_TAPS) r = CNT_W'(MAX_TAPS);
      else r = CNT_W'(t);
      return r;
    end
  endfunction

endpackage

[hdl/iir_half_band_oversampler_top.sv]
// Two-times IIR oversampler, direct form I, shared MAC.
// Input stream (s_axis): command/channel/coef_index/value. Load commands
// write a coefficient and give no item out. An upsample item
// gives two output items (filtered 2*x, then filtered zero, tlast on the
// second); a downsample item gives one item on even phase, none on odd.
// Each filtered sample runs the feedforward taps and the feedback taps
// from a1 on through the MAC, then pipeline drain, rounding and handoff.
// An upsample item holds the input through both of its filtered samples
// and a downsample item through one; the single multiplier and
// the one-read-per-cycle history memories serialise that work.
// Histories live in rings addressed by a per-stream head pointer, so
// reset only clears pointers' valid span: entries older than the number
// of samples written read as zero through a fill count.
// Output is a single register; while the receiver holds tready low the
// block goes on to the next filtered sample, then waits with that result
// and takes no input. Reset (rst, synchronous) clears coefficients, phases
// and fill counts and sets both tap counts to 16; no clearing pass is needed.
// cfg port: cfg_we, cfg_index (0 feedforward_taps, 1 feedback_taps).
module iir_half_band_oversampler_top import ihb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // command[1:0], channel[2], coef_index[6:3], value[30:7]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // sample[23:0]
  output logic        m_axis_tlast,
  output logic [1:0]  m_axis_tuser    // out_channel[0], saturated[1]
);
`include "iir_half_band_oversampler_top_macros.svh"

  localparam int NSTR  = 2 * CHANNELS;
  localparam int DEPTH = 2 ** HIST_W;

  logic [1:0]  in_cmd;
  logic [0:0]  in_ch;
  logic [3:0]  in_idx;
  logic signed [23:0] in_val;
  assign in_cmd = s_axis_tdata[1:0];
  assign in_ch  = s_axis_tdata[2];
  assign in_idx = s_axis_tdata[6:3];
  assign in_val = s_axis_tdata[30:7];

  logic [4:0] ff_taps, fb_taps;
  logic signed [23:0] bcoef [MAX_TAPS];
  logic signed [23:0] acoef [MAX_TAPS];

  // history rings: one memory for x, one for y
  logic signed [24:0] xmem [DEPTH];
  logic signed [23:0] ymem [DEPTH];
  logic signed [24:0] xrd;
  logic signed [23:0] yrd;

  logic [TAP_W-1:0] head [NSTR];
  logic [CNT_W-1:0] fill [NSTR];
  logic [CHANNELS-1:0] phase;

  state_t state, state_next;
  logic [CH_W-1:0] ch;
  logic        down, second;
  logic [CNT_W-1:0] j, j_next;
  logic [1:0]  drain, drain_next;
  logic        rd_vld, rd_fb, rd_zero;
  logic [TAP_W-1:0] rd_j;
  logic signed [ACC_W-1:0] acc;
  logic        mac_clear, mac_en;
  logic signed [23:0] res;
  logic        res_sat, emit, out_last;
  logic [CNT_W-1:0] nb, na;
  logic [$clog2(NSTR)-1:0] sid;

  assign nb  = clamp_taps(ff_taps);
  assign na  = clamp_taps(fb_taps);
  assign sid = {ch, down};

  logic accept;
  assign s_axis_tready = (state == ST_IDLE);
  assign accept = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ff_taps <= 5'd16;
      fb_taps <= 5'd16;
    end else if (cfg_we) begin
      if (cfg_index == CFG_FF) ff_taps <= cfg_data;
      else fb_taps <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_TAPS; i++) begin
        bcoef[i] <= '0;
        acoef[i] <= '0;
      end
    end else if (accept && in_cmd == CMD_LOAD_B) begin
      bcoef[in_idx] <= in_val;
    end else if (accept && in_cmd == CMD_LOAD_A) begin
      acoef[in_idx] <= in_val;
    end
  end

  // sample being filtered enters the x ring at start of each pass
  logic start_pass;
  logic signed [24:0] new_x;
  logic [CH_W-1:0] start_ch;
  logic start_down;
  always_comb begin
    start_pass = 1'b0;
    new_x      = '0;
    start_ch   = ch;
    start_down = down;
    if (accept && (in_cmd == CMD_UP || in_cmd == CMD_DOWN) && 32'(in_ch) < CHANNELS) begin
      start_pass = 1'b1;
      start_ch   = CH_W'(in_ch);
      start_down = (in_cmd == CMD_DOWN);
      new_x = (in_cmd == CMD_UP) ? {in_val, 1'b0} : 25'(in_val);
    end else if (state == ST_OUT && !m_axis_tvalid && !down && !second) begin
      start_pass = 1'b1;  // stuffed zero of upsample
    end
  end

  logic [HIST_W-1:0] wr_x_addr;
  logic [TAP_W-1:0] nh;
  assign nh = head[{start_ch, start_down}] + TAP_W'(1);
  assign wr_x_addr = {start_ch, start_down, nh};

  always_ff @(posedge clk) begin
    if (start_pass) xmem[wr_x_addr] <= new_x;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NSTR; i++) begin
        head[i] <= '0;
        fill[i] <= '0;
      end
    end else begin
      if (start_pass) begin
        head[{start_ch, start_down}] <= nh;
        if (fill[{start_ch, start_down}] != CNT_W'(MAX_TAPS))
          fill[{start_ch, start_down}] <= fill[{start_ch, start_down}] + CNT_W'(1);
      end
    end
  end

  // y ring slot for output written at OUT uses head (same slot as x)
  always_ff @(posedge clk) begin
    if (state == ST_OUT && !m_axis_tvalid) ymem[{ch, down, head[sid]}] <= res;
  end

  // read addresses: x[n-j] = head - j ; y[n-j] = head - j (y newest is head-1)
  logic [HIST_W-1:0] rd_addr;
  logic              rd_fb_c;
  logic [TAP_W-1:0]  rd_off;
  always_comb begin
    rd_fb_c = (state == ST_FB);
    rd_off  = head[sid] - j[TAP_W-1:0];
    rd_addr = {ch, down, rd_off};
  end

  always_ff @(posedge clk) begin
    xrd     <= xmem[rd_addr];
    yrd     <= ymem[rd_addr];
    rd_fb   <= rd_fb_c;
    rd_j    <= j[TAP_W-1:0];
    // entry older than the fill count reads as zero
    rd_zero <= rd_fb_c ? (j > fill[sid] - CNT_W'(1)) : (j >= fill[sid]);
    rd_vld  <= (state == ST_FF) || (state == ST_FB);
  end

  logic signed [23:0] mc;
  logic signed [24:0] md;
  always_comb begin
    mc = rd_fb ? acoef[rd_j] : bcoef[rd_j];
    md = rd_zero ? 25'sd0 : (rd_fb ? 25'(yrd) : xrd);
  end
  assign mac_en = rd_vld;

  ihb_mac u_mac (
    .clk  (clk),
    .clear(mac_clear),
    .en   (mac_en),
    .sub  (rd_fb),
    .coef (mc),
    .data (md),
    .acc  (acc)
  );

  // round and saturate
  logic signed [ACC_W-1:0] rnd;
  logic signed [ACC_W-21:0] ysh;
  assign rnd = acc + ACC_W'(64'sd1 <<< 19);
  assign ysh = rnd[ACC_W-1:20];

  always_ff @(posedge clk) begin
    if (state == ST_ROUND) begin
      if (ysh > 44'sd8388607) begin
        res <= 24'sd8388607; res_sat <= 1'b1;
      end else if (ysh < -44'sd8388608) begin
        res <= -24'sd8388608; res_sat <= 1'b1;
      end else begin
        res <= ysh[23:0]; res_sat <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    j_next     = j;
    drain_next = drain;
    mac_clear  = 1'b0;
    emit       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start_pass) begin
          state_next = ST_FF;
          j_next     = '0;
          mac_clear  = 1'b1;
        end
      end
      ST_FF: begin
        if (j + CNT_W'(1) >= nb) begin
          if (na > CNT_W'(1)) begin
            state_next = ST_FB; j_next = CNT_W'(1);
          end else begin
            state_next = ST_DRAIN; drain_next = '0;
          end
        end else begin
          j_next = j + CNT_W'(1);
        end
      end
      ST_FB: begin
        if (j + CNT_W'(1) >= na) begin
          state_next = ST_DRAIN; drain_next = '0;
        end else begin
          j_next = j + CNT_W'(1);
        end
      end
      ST_DRAIN: begin
        drain_next = drain + 2'd1;
        if (drain == 2'd2) state_next = ST_ROUND;
      end
      ST_ROUND: state_next = ST_OUT;
      ST_OUT: begin
        emit = !down || !phase[ch];
        if (!m_axis_tvalid) begin
          if (!down && !second) begin
            state_next = ST_FF; j_next = '0; mac_clear = 1'b1;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // stuffed-zero pass starts from ST_OUT with x = 0 (new_x default)
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      j      <= '0;
      drain  <= '0;
      ch     <= '0;
      down   <= 1'b0;
      second <= 1'b0;
      phase  <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      j     <= j_next;
      drain <= drain_next;
      if (accept && start_pass) begin
        ch     <= start_ch;
        down   <= start_down;
        second <= 1'b0;
      end else if (state == ST_OUT && state_next == ST_FF) begin
        second <= 1'b1;
      end
      if (state == ST_OUT && !m_axis_tvalid) begin
        if (down) phase[ch] <= ~phase[ch];
        if (emit) m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && !m_axis_tvalid) begin
      m_axis_tdata    <= res;
      m_axis_tlast    <= down || second;
      m_axis_tuser[0] <= 1'(ch);
      m_axis_tuser[1] <= res_sat;
    end
  end
  assign out_last = down || second;

  `IHB_ASSERT_IMP(a_busy_not_ready, clk, rst, state != ST_IDLE, !s_axis_tready,
    "ready while busy")
  `IHB_ASSERT_NEXT(a_hold_out, clk, rst, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "output dropped while stalled")
  `IHB_ASSERT_IMP(a_down_last, clk, rst, state == ST_OUT && down, out_last,
    "downsample result without last")
  `IHB_ASSERT_IMP(a_j_range, clk, rst, state == ST_FB, j != '0,
    "feedback tap zero used")

endmodule

[hdl/ihb_mac.sv]
// Registered signed multiply-accumulate: product stage then accumulate stage.
module ihb_mac import ihb_pkg::*; (
  input  logic                    clk,
  input  logic                    clear,
  input  logic                    en,
  input  logic                    sub,
  input  logic signed [23:0]      coef,
  input  logic signed [24:0]      data,
  output logic signed [ACC_W-1:0] acc
);
  logic signed [48:0] prod;
  logic               prod_vld;
  logic               prod_sub;

  always_ff @(posedge clk) begin
    prod     <= coef * data;
    prod_vld <= en & ~clear;
    prod_sub <= sub;
    if (clear) begin
      acc <= '0;
    end else if (prod_vld) begin
      if (prod_sub) acc <= acc - ACC_W'(prod);
      else acc <= acc + ACC_W'(prod);
    end
  end
endmodule

[sim/iir_half_band_oversampler_top_test.sv]
module iir_half_band_oversampler_top_test;
  import ihb_pkg::*;

  typedef struct {
    logic [23:0] sample;
    logic        chan;
    logic        last;
    logic        sat;
  } filt_out_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [4:0]  cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [1:0]  m_axis_tuser;

  iir_half_band_oversampler_top u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .m_axis_tuser(m_axis_tuser)
  );

  // filter state mirror
  logic signed [23:0] num_coef [MAX_TAPS];
  logic signed [23:0] den_coef [MAX_TAPS];
  logic signed [24:0] x_hist [2][CHANNELS][MAX_TAPS];  // [down][channel]
  logic signed [23:0] y_hist [2][CHANNELS][MAX_TAPS];
  logic               down_odd [CHANNELS];
  logic [4:0]         ff_taps, fb_taps;

  filt_out_t expected_q[$];
  int  errors = 0, n_items = 0, n_results = 0, n_sat = 0;
  bit  src_burst, sink_burst;
  int  sink_hold;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("FAILURE");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(50, 200);
  endfunction

  function automatic int eff_taps(logic [4:0] t);
    if (t == 0) return 1;
    if (t > MAX_TAPS) return MAX_TAPS;
    return int'(t);
  endfunction

  function automatic void iir_filter(bit dn, logic chn, logic signed [24:0] x,
                                     output logic [23:0] y_out, output logic sat);
    longint acc, y;
    int nb, na;
    nb = eff_taps(ff_taps);
    na = eff_taps(fb_taps);
    for (int j = MAX_TAPS - 1; j > 0; j--) x_hist[dn][chn][j] = x_hist[dn][chn][j-1];
    x_hist[dn][chn][0] = x;
    acc = 0;
    for (int j = 0; j < nb; j++)
      acc += longint'(num_coef[j]) * longint'(x_hist[dn][chn][j]);
    for (int j = 1; j < na; j++)
      acc -= longint'(den_coef[j]) * longint'(y_hist[dn][chn][j-1]);
    y = (acc + (64'sd1 <<< 19)) >>> 20;
    sat = 1'b0;
    if (y > 8388607) begin
      y = 8388607;
      sat = 1'b1;
    end else if (y < -8388608) begin
      y = -8388608;
      sat = 1'b1;
    end
    for (int j = MAX_TAPS - 1; j > 0; j--) y_hist[dn][chn][j] = y_hist[dn][chn][j-1];
    y_hist[dn][chn][0] = y[23:0];
    y_out = y[23:0];
  endfunction

  function automatic void predict_item(cmd_t cmd, logic chn, logic [3:0] idx,
                                       logic signed [23:0] v);
    filt_out_t r;
    case (cmd)
      CMD_LOAD_B: num_coef[idx] = v;
      CMD_LOAD_A: den_coef[idx] = v;
      CMD_UP: begin
        r.chan = chn;
        iir_filter(0, chn, 25'(v) <<< 1, r.sample, r.sat);
        r.last = 1'b0;
        expected_q.push_back(r);
        iir_filter(0, chn, 25'sd0, r.sample, r.sat);
        r.last = 1'b1;
        expected_q.push_back(r);
      end
      CMD_DOWN: begin
        r.chan = chn;
        r.last = 1'b1;
        iir_filter(1, chn, 25'(v), r.sample, r.sat);
        if (!down_odd[chn]) expected_q.push_back(r);
        down_odd[chn] = ~down_odd[chn];
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(cmd_t cmd, logic chn, logic [3:0] idx, logic [23:0] v);
    int gap;
    gap = src_burst ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, v, idx, chn, cmd};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_item(cmd, chn, idx, v);
    n_items++;
  endtask

  // drain outputs, then let a trailing load or odd phase item finish
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_cfg(logic which, logic [4:0] d);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= which;
    cfg_data  <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (which == CFG_FF) ff_taps = d;
    else fb_taps = d;
  endtask

  function automatic logic [23:0] rand_coef(bit fb);
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return 24'($urandom);
    if (fb) return 24'($urandom_range(0, 1 << 16) - (1 << 15));
    return 24'($urandom_range(0, 1 << 19) - (1 << 18));
  endfunction

  function automatic logic [23:0] rand_sample();
    logic signed [23:0] s;
    s = 24'($urandom);
    if ($urandom_range(0, 99) < 70) s = s >>> $urandom_range(1, 8);
    return s;
  endfunction

  // sink side
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_hold = 0;
    end else if (sink_hold > 0) begin
      m_axis_tready <= 1'b0;
      sink_hold--;
    end else begin
      m_axis_tready <= 1'b1;
      if (!sink_burst && $urandom_range(0, 99) < 30) sink_hold = pick_gap();
    end
  end

  always @(posedge clk) begin
    filt_out_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected item: sample %h", m_axis_tdata);
        errors++;
      end else begin
        e = expected_q.pop_front();
        n_results++;
        if (e.sat) n_sat++;
        if (m_axis_tdata !== e.sample) begin
          $error("sample: expected %h actual %h", e.sample, m_axis_tdata);
          errors++;
        end
        if (m_axis_tuser[0] !== e.chan) begin
          $error("out_channel: expected %0d actual %0d", e.chan, m_axis_tuser[0]);
          errors++;
        end
        if (m_axis_tlast !== e.last) begin
          $error("last: expected %0d actual %0d", e.last, m_axis_tlast);
          errors++;
        end
        if (m_axis_tuser[1] !== e.sat) begin
          $error("saturated: expected %0d actual %0d", e.sat, m_axis_tuser[1]);
          errors++;
        end
      end
    end
  end

  task automatic test_reset_state();
    // all coefficients clear: everything filters to zero
    send_item(CMD_UP, 1'b0, 4'd0, 24'h7FFFFF);
    send_item(CMD_DOWN, 1'b1, 4'd0, 24'h800000);
    send_item(CMD_DOWN, 1'b1, 4'd0, 24'h123456);
  endtask

  task automatic test_directed();
    send_item(CMD_LOAD_B, 1'b0, 4'd0, 24'h100000);   // b0 = 1.0
    send_item(CMD_LOAD_A, 1'b1, 4'd0, 24'h7FFFFF);   // a0 never used
    send_item(CMD_UP, 1'b0, 4'd0, 24'h7FFFFF);       // 2x clips high
    send_item(CMD_UP, 1'b1, 4'd15, 24'h800000);      // clips low
    send_item(CMD_UP, 1'b0, 4'd0, 24'h000001);
    send_item(CMD_DOWN, 1'b0, 4'd0, 24'h7FFFFF);
    send_item(CMD_DOWN, 1'b0, 4'd0, 24'h800000);
    send_item(CMD_LOAD_B, 1'b0, 4'd15, 24'h800000);
    send_item(CMD_LOAD_A, 1'b0, 4'd15, 24'h7FFFFF);
    send_item(CMD_LOAD_A, 1'b0, 4'd1, 24'hF80000);   // a1 = -0.5
    send_item(CMD_DOWN, 1'b1, 4'd0, 24'h400000);
    send_item(CMD_UP, 1'b1, 4'd0, 24'hC00000);
    send_item(CMD_UP, 1'b0, 4'd0, 24'hFFFFFF);
    send_item(CMD_LOAD_B, 1'b0, 4'd1, 24'h080000);   // half-LSB rounding
    send_item(CMD_UP, 1'b0, 4'd0, 24'h000001);
  endtask

  task automatic test_tap_counts();
    logic [4:0] counts [6] = '{5'd0, 5'd1, 5'd16, 5'd17, 5'd31, 5'd2};
    foreach (counts[k]) begin
      write_cfg(CFG_FF, counts[k]);
      write_cfg(CFG_FB, counts[5-k]);
      for (int i = 0; i < 6; i++)
        send_item(cmd_t'($urandom_range(CMD_UP, CMD_DOWN)), 1'($urandom),
                  4'($urandom), rand_sample());
    end
  endtask

  task automatic test_random_traffic();
    int r;
    for (int blk = 0; blk < 6; blk++) begin
      r = $urandom_range(0, 9);
      write_cfg(CFG_FF, r == 0 ? 5'($urandom) : 5'($urandom_range(1, 16)));
      write_cfg(CFG_FB, r == 1 ? 5'($urandom) : 5'($urandom_range(1, 16)));
      src_burst  = (blk % 3 == 1);
      sink_burst = (blk % 3 == 2);
      for (int i = 0; i < 300; i++) begin
        r = $urandom_range(0, 99);
        if (r < 6)
          send_item(CMD_LOAD_B, 1'($urandom), 4'($urandom), rand_coef(0));
        else if (r < 12)
          send_item(CMD_LOAD_A, 1'($urandom), 4'($urandom), rand_coef(1));
        else
          send_item(r < 55 ? CMD_UP : CMD_DOWN, 1'($urandom), 4'($urandom),
                    rand_sample());
      end
    end
    src_burst  = 0;
    sink_burst = 0;
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    src_burst = 0; sink_burst = 0;
    ff_taps = 5'd16;
    fb_taps = 5'd16;
    for (int j = 0; j < MAX_TAPS; j++) begin
      num_coef[j] = '0;
      den_coef[j] = '0;
      for (int c = 0; c < CHANNELS; c++) begin
        for (int d = 0; d < 2; d++) begin
          x_hist[d][c][j] = '0;
          y_hist[d][c][j] = '0;
        end
      end
    end
    for (int c = 0; c < CHANNELS; c++) down_odd[c] = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_directed();
    test_tap_counts();
    test_random_traffic();
    wait_idle();

    $display("Sent %0d items (loads, up and down samples over both channels)", n_items);
    $display("Checked %0d output items, %0d of them clipped", n_results, n_sat);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
